/* src/eid_alloc_pkg.sv */
// Shared types and field widths for the entity ID allocator.
package eid_alloc_pkg;

    // Fixed field widths of the command and result words
    localparam int CMD_W      = 2;
    localparam int ID_IN_W    = 16;
    localparam int SIG_IN_W   = 32;
    localparam int ID_OUT_W   = 12;
    localparam int SIG_OUT_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_SET_SIG = 2'd2,
        CMD_GET_SIG = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

endpackage

/* src/eid_alloc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module eid_alloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/entity_id_allocator_core.sv */
// Entity ID allocator: FIFO free list and signature store held in RAM.
// o_valid rises once the command word has passed the stage 1 and output registers.
// Throughput: one command per cycle while the result channel is not stalled; all
// pointer and count updates finish in the accept cycle, and the free-list and signature
// RAM reads return in the cycle after.
// Reset: pointers and live count clear at once; the signature RAM is then swept
// to zero over all MAX_IDS entries (4096 by default) with o_ready low during the sweep.
module entity_id_allocator_core #(
    parameter int MAX_IDS  = 4096,
    parameter int SIG_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [eid_alloc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [eid_alloc_pkg::ID_IN_W-1:0]   i_entity_id,
    input  logic [eid_alloc_pkg::SIG_IN_W-1:0]  i_signature_in,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [eid_alloc_pkg::ID_OUT_W-1:0]  o_entity_id_out,
    output logic [eid_alloc_pkg::SIG_OUT_W-1:0] o_signature_out,
    output logic [eid_alloc_pkg::STATUS_W-1:0]  o_status,
    output logic [eid_alloc_pkg::COUNT_W-1:0]   o_living_count
);
    import eid_alloc_pkg::*;

    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int CNT_W = $clog2(MAX_IDS + 1);

    localparam logic [ID_W-1:0]    LAST_IDX  = ID_W'(MAX_IDS - 1);
    localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_IDS);
    localparam logic [ID_IN_W:0]   ID_LIMIT  = (ID_IN_W + 1)'(MAX_IDS);

    // Control state
    logic             r_clearing;
    logic [ID_W-1:0]  r_clr_addr;
    logic [ID_W-1:0]  r_head, n_head;
    logic [ID_W-1:0]  r_tail, n_tail;
    logic             r_fq_filled, n_fq_filled;
    logic [CNT_W-1:0] r_live, n_live;

    // Stage 1: decision made, RAM read in flight
    logic             r_s1_valid;
    logic             r_s1_create_ok;
    logic             r_s1_get_ok;
    logic             r_s1_fq_written;
    logic [ID_W-1:0]  r_s1_head;
    t_status          r_s1_status;
    logic [CNT_W-1:0] r_s1_count;

    // Output register
    logic                 r_out_valid;
    logic [ID_OUT_W-1:0]  r_out_id,     n_out_id;
    logic [SIG_OUT_W-1:0] r_out_sig,    n_out_sig;
    t_status              r_out_status;
    logic [COUNT_W-1:0]   r_out_count;

    // Command decode
    t_cmd             cmd;
    logic             accept;
    logic             out_free;
    logic             s1_move;
    logic             in_range;
    logic             create_ok;
    logic             destroy_ok;
    logic             set_ok;
    logic             get_ok;
    t_status          status;
    logic [ID_W-1:0]  id_idx;

    // RAM ports
    logic             sig_we;
    logic [ID_W-1:0]  sig_waddr;
    logic [SIG_BITS-1:0] sig_wdata;
    logic [SIG_BITS-1:0] sig_rdata;
    logic [ID_W-1:0]  fq_rdata;

    // Handshake
    assign out_free = !r_out_valid || i_ready;
    assign s1_move  = r_s1_valid && out_free;
    assign o_ready  = !r_clearing && (!r_s1_valid || out_free);
    assign accept   = i_valid && o_ready;

    assign cmd      = t_cmd'(i_cmd);
    assign id_idx   = i_entity_id[ID_W-1:0];
    assign in_range = {1'b0, i_entity_id} < ID_LIMIT;

    // Classify the command against current state
    always_comb begin
        create_ok  = 1'b0;
        destroy_ok = 1'b0;
        set_ok     = 1'b0;
        get_ok     = 1'b0;
        status     = ST_OK;
        case (cmd)
            CMD_CREATE: begin
                if (r_live == MAX_CNT) begin
                    status = ST_FULL;
                end else begin
                    create_ok = 1'b1;
                end
            end
            CMD_DESTROY: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (r_live == '0) begin
                    status = ST_UNDERFLOW;
                end else begin
                    destroy_ok = 1'b1;
                end
            end
            CMD_SET_SIG: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    set_ok = 1'b1;
                end
            end
            CMD_GET_SIG: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    get_ok = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Advance pointers and live count
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fq_filled = r_fq_filled;
        n_live      = r_live;
        if (accept && create_ok) begin
            n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
            n_live = r_live + 1'b1;
        end
        if (accept && destroy_ok) begin
            if (r_tail == LAST_IDX) begin
                n_tail      = '0;
                n_fq_filled = 1'b1;
            end else begin
                n_tail = r_tail + 1'b1;
            end
            n_live = r_live - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fq_filled <= 1'b0;
            r_live      <= '0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == LAST_IDX) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fq_filled <= n_fq_filled;
            r_live      <= n_live;
        end
    end

    // Signature store: sweep to zero after reset, else set or clear on destroy
    always_comb begin
        sig_we    = 1'b0;
        sig_waddr = id_idx;
        sig_wdata = '0;
        if (r_clearing) begin
            sig_we    = 1'b1;
            sig_waddr = r_clr_addr;
        end else if (accept && set_ok) begin
            sig_we    = 1'b1;
            sig_wdata = SIG_BITS'(i_signature_in);
        end else if (accept && destroy_ok) begin
            sig_we    = 1'b1;
        end
    end

    eid_alloc_ram #(
        .WIDTH (SIG_BITS),
        .DEPTH (MAX_IDS)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (sig_we),
        .i_waddr (sig_waddr),
        .i_wdata (sig_wdata),
        .i_re    (accept),
        .i_raddr (id_idx),
        .o_rdata (sig_rdata)
    );

    // Free list: push freed ID at tail, read oldest at head
    eid_alloc_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (accept && destroy_ok),
        .i_waddr (r_tail),
        .i_wdata (id_idx),
        .i_re    (accept),
        .i_raddr (r_head),
        .o_rdata (fq_rdata)
    );

    // Stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload; an entry never written since reset is taken as its own index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_create_ok  <= create_ok;
            r_s1_get_ok     <= get_ok;
            r_s1_fq_written <= r_fq_filled || (r_head < r_tail);
            r_s1_head       <= r_head;
            r_s1_status     <= status;
            r_s1_count      <= n_live;
        end
    end

    // Merge RAM read data into the result word
    always_comb begin
        n_out_id  = '0;
        n_out_sig = '0;
        if (r_s1_create_ok) begin
            n_out_id = r_s1_fq_written ? ID_OUT_W'(fq_rdata) : ID_OUT_W'(r_s1_head);
        end
        if (r_s1_get_ok) begin
            n_out_sig = SIG_OUT_W'(sig_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_id     <= n_out_id;
            r_out_sig    <= n_out_sig;
            r_out_status <= r_s1_status;
            r_out_count  <= COUNT_W'(r_s1_count);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_entity_id_out = r_out_id;
    assign o_signature_out = r_out_sig;
    assign o_status        = r_out_status;
    assign o_living_count  = r_out_count;

`ifndef NO_ASSERTIONS
    // Live count never passes the number of IDs
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= MAX_CNT)
        else $error("live count above MAX_IDS");

    // No command is taken while the signature sweep runs
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_ready)
        else $error("command accepted during signature sweep");

    // A successful create bumps the live count by one
    a_create_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && create_ok) |=> (r_live == $past(r_live) + 1'b1))
        else $error("create did not advance live count");

    // A stalled stage 1 word is kept until the output frees up
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |=> (r_s1_valid && $stable(r_s1_count)))
        else $error("stage 1 word lost under stall");
`endif

endmodule
